### sv/csb_pkg.sv
// package for the clipped scaled pixel blitter: beat payloads, csr layout,
// controller states and the command / status groups between ctrl and datapath
// no dependencies
`default_nettype none

package csb_pkg;

   // csr port layout
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_WIDTH = 3'd6;

   // csr reset values
   localparam logic [7:0]  SCALE_RESET = 8'd16;
   localparam logic [12:0] RECT_RESET  = 13'd1;

   // pixel word layout
   localparam int         ALPHA_LSB    = 24;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   localparam int ADDR_W = 24;

   typedef struct packed {
      logic [31:0] pixel_color;
      logic        start_req;
   } csb_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] dst_addr;
      logic [31:0]       color;
      logic              last;
   } csb_rsp_type;

   typedef struct packed {
      logic [12:0]        dst_width;
      logic [12:0]        dst_height;
      logic signed [12:0] pos_x;
      logic signed [12:0] pos_y;
      logic [7:0]         scale_x;
      logic [7:0]         scale_y;
      logic [12:0]        rect_width;
   } csb_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_CLIP,
      ST_ROW,
      ST_EMIT
   } csb_state_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic span_en;
      logic clip_en;
      logic row_en;
      logic emit_en;
   } csb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic opaque;
      logic empty;
      logic out_free;
      logic col_last;
      logic row_last;
   } csb_sts_type;

endpackage

`default_nettype wire

### sv/clipped_scaled_pixel_blitter.sv
// top level of the clipped scaled pixel blitter: csr block, controller and
// datapath; depends on csb_pkg, csb_csr, csb_ctrl, csb_dp
//
//   channel | ports                                   | beat
//   --------+-----------------------------------------+---------------------------
//   input   | req_valid, req_stall, req_data          | source pixel, start flag
//   result  | rsp_valid, rsp_stall, rsp_data          | word address, color, last
//   config  | csr_wr_en, csr_index, csr_wdata         | one register write
//
// a pixel that is not opaque is taken while idle and writes nothing; an
// opaque pixel is sequenced by the controller through span, clip (back to
// idle if the clip is empty), one row-base multiply per row and one write per cycle.
// reset is synchronous: position and output valid are cleared, registers take their reset values.
// rsp_stall holds the output beat and pauses the write loop; req_stall is
// high whenever the controller is not idle.
`default_nettype none

module clipped_scaled_pixel_blitter #(
   parameter int MAX_DIM         = 4096,
   parameter int SCALE_FRAC_BITS = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire csb_pkg::csb_req_type            req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output csb_pkg::csb_rsp_type                 rsp_data,
   input  wire logic                            csr_wr_en,
   input  wire logic [csb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [csb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   csb_pkg::csb_cfg_type cfg;
   csb_pkg::csb_cmd_type cmd;
   csb_pkg::csb_sts_type sts;

   csb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   csb_dp #(
      .MAX_DIM         (MAX_DIM),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### sv/csb_csr.sv
// configuration registers of the blitter, written through a plain write port
// depends on csb_pkg
`default_nettype none

module csb_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [csb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [csb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output csb_pkg::csb_cfg_type                  cfg
);

   csb_pkg::csb_cfg_type cfg_ff;
   csb_pkg::csb_cfg_type cfg_in;

   // register write decode, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            csb_pkg::CSR_DST_WIDTH:  cfg_in.dst_width  = csr_wdata;
            csb_pkg::CSR_DST_HEIGHT: cfg_in.dst_height = csr_wdata;
            csb_pkg::CSR_POS_X:      cfg_in.pos_x      = $signed(csr_wdata);
            csb_pkg::CSR_POS_Y:      cfg_in.pos_y      = $signed(csr_wdata);
            csb_pkg::CSR_SCALE_X:    cfg_in.scale_x    = csr_wdata[7:0];
            csb_pkg::CSR_SCALE_Y:    cfg_in.scale_y    = csr_wdata[7:0];
            csb_pkg::CSR_RECT_WIDTH: cfg_in.rect_width = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dst_width  <= '0;
         cfg_ff.dst_height <= '0;
         cfg_ff.pos_x      <= '0;
         cfg_ff.pos_y      <= '0;
         cfg_ff.scale_x    <= csb_pkg::SCALE_RESET;
         cfg_ff.scale_y    <= csb_pkg::SCALE_RESET;
         cfg_ff.rect_width <= csb_pkg::RECT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### sv/csb_ctrl.sv
// controller state machine of the blitter: sequences span, clip, row and
// write beats of one pixel; depends on csb_pkg
`default_nettype none

module csb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire csb_pkg::csb_sts_type  sts,
   output csb_pkg::csb_cmd_type       cmd
);

   csb_pkg::csb_state_type state_ff;
   csb_pkg::csb_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csb_pkg::ST_IDLE: begin
            if (req_valid && sts.opaque) state_in = csb_pkg::ST_SPAN;
         end
         csb_pkg::ST_SPAN: state_in = csb_pkg::ST_CLIP;
         csb_pkg::ST_CLIP: begin
            state_in = sts.empty ? csb_pkg::ST_IDLE : csb_pkg::ST_ROW;
         end
         csb_pkg::ST_ROW: state_in = csb_pkg::ST_EMIT;
         csb_pkg::ST_EMIT: begin
            if (sts.out_free && sts.col_last) begin
               state_in = sts.row_last ? csb_pkg::ST_IDLE : csb_pkg::ST_ROW;
            end
         end
         default: state_in = csb_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         csb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         csb_pkg::ST_SPAN: cmd.span_en = 1'b1;
         csb_pkg::ST_CLIP: cmd.clip_en = 1'b1;
         csb_pkg::ST_ROW:  cmd.row_en  = 1'b1;
         csb_pkg::ST_EMIT: cmd.emit_en = sts.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### sv/csb_dp.sv
// datapath of the blitter: source position, scaled span, clipping, row base
// multiply, write loop counters and the output beat register; depends on csb_pkg
`default_nettype none

module csb_dp #(
   parameter int MAX_DIM         = 4096,
   parameter int SCALE_FRAC_BITS = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire csb_pkg::csb_req_type  req_data,
   input  wire csb_pkg::csb_cfg_type  cfg,
   input  wire csb_pkg::csb_cmd_type  cmd,
   output csb_pkg::csb_sts_type       sts,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output csb_pkg::csb_rsp_type       rsp_data
);

   localparam int CW  = $clog2(MAX_DIM);        // source column / row
   localparam int DW  = $clog2(MAX_DIM + 1);    // destination coordinate 0..MAX_DIM
   localparam int LW  = ((DW > 13) ? DW : 13) + 1;
   localparam int PX  = 8 + CW;                 // scale times index
   localparam int QW  = ((PX > 13 + SCALE_FRAC_BITS) ? PX : 13 + SCALE_FRAC_BITS) + 2;
   localparam int PW  = 2 * DW;                 // row base
   localparam int SW  = (PW + 1 > csb_pkg::ADDR_W) ? PW + 1 : csb_pkg::ADDR_W;
   localparam int SCALE_CAP = 8 << SCALE_FRAC_BITS;

   // clamped configuration
   logic [7:0]    sx;
   logic [7:0]    sy;
   logic [DW-1:0] w;
   logic [DW-1:0] h;
   logic [LW-1:0] w_ext;
   logic [LW-1:0] h_ext;
   logic [LW-1:0] rw_ext;
   logic [LW-1:0] limit;

   always_comb begin
      sx = ({8'd0, cfg.scale_x} > 16'(SCALE_CAP)) ? 8'(SCALE_CAP) : cfg.scale_x;
      sy = ({8'd0, cfg.scale_y} > 16'(SCALE_CAP)) ? 8'(SCALE_CAP) : cfg.scale_y;
      w_ext = LW'(cfg.dst_width);
      h_ext = LW'(cfg.dst_height);
      if (w_ext > LW'(MAX_DIM)) w_ext = LW'(MAX_DIM);
      if (h_ext > LW'(MAX_DIM)) h_ext = LW'(MAX_DIM);
      w = w_ext[DW-1:0];
      h = h_ext[DW-1:0];
      rw_ext = LW'(cfg.rect_width);
      if (rw_ext == '0) begin
         limit = LW'(1);
      end else if (rw_ext > LW'(MAX_DIM)) begin
         limit = LW'(MAX_DIM);
      end else begin
         limit = rw_ext;
      end
   end

   // source position, applied at every taken beat
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] col_use, row_use;
   logic [CW-1:0] item_col_ff, item_row_ff;
   logic [31:0]   color_ff;

   always_comb begin
      col_use = req_data.start_req ? '0 : col_ff;
      row_use = req_data.start_req ? '0 : row_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (cmd.take) begin
         if (LW'(col_use) + LW'(1) >= limit) begin
            col_in = '0;
            row_in = (LW'(row_use) + LW'(1) >= LW'(MAX_DIM)) ? '0 : row_use + CW'(1);
         end else begin
            col_in = col_use + CW'(1);
            row_in = row_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_col_ff <= col_use;
         item_row_ff <= row_use;
         color_ff    <= req_data.pixel_color;
      end
   end

   assign sts.opaque = (req_data.pixel_color[csb_pkg::ALPHA_LSB +: 8] == csb_pkg::ALPHA_OPAQUE);

   // span start in fixed point: scale * index + pos
   logic [PX-1:0]        prod_x, prod_y;
   logic signed [QW-1:0] x0q_ff, y0q_ff;

   assign prod_x = PX'(sx) * PX'(item_col_ff);
   assign prod_y = PX'(sy) * PX'(item_row_ff);

   always_ff @(posedge clock) begin
      if (cmd.span_en) begin
         x0q_ff <= $signed(QW'(prod_x)) + (QW'(cfg.pos_x) <<< SCALE_FRAC_BITS);
         y0q_ff <= $signed(QW'(prod_y)) + (QW'(cfg.pos_y) <<< SCALE_FRAC_BITS);
      end
   end

   // floor both ends, reject and clip
   logic signed [QW-1:0] x0f, x1f, y0f, y1f, w_s, h_s;
   logic [DW-1:0]        x0c, x1c, y0c, y1c;
   logic                 reject;

   always_comb begin
      w_s = $signed(QW'(w));
      h_s = $signed(QW'(h));
      x0f = x0q_ff >>> SCALE_FRAC_BITS;
      y0f = y0q_ff >>> SCALE_FRAC_BITS;
      x1f = (x0q_ff + $signed(QW'(sx))) >>> SCALE_FRAC_BITS;
      y1f = (y0q_ff + $signed(QW'(sy))) >>> SCALE_FRAC_BITS;
      reject = (x1f < 0) || (y1f < 0) || (x0f > w_s) || (y0f > h_s);
      x0c = (x0f < 0) ? '0 : x0f[DW-1:0];
      y0c = (y0f < 0) ? '0 : y0f[DW-1:0];
      x1c = (x1f > w_s) ? w : x1f[DW-1:0];
      y1c = (y1f > h_s) ? h : y1f[DW-1:0];
   end

   assign sts.empty = reject || (x0c >= x1c) || (y0c >= y1c);

   // write loop counters
   logic [DW-1:0] x_lo_ff, x_hi_ff, y_hi_ff;
   logic [DW-1:0] x_ff, y_ff;
   logic [PW-1:0] base_ff;

   assign sts.col_last = ({1'b0, x_ff} + (DW + 1)'(1)) == {1'b0, x_hi_ff};
   assign sts.row_last = ({1'b0, y_ff} + (DW + 1)'(1)) == {1'b0, y_hi_ff};

   always_ff @(posedge clock) begin
      if (cmd.clip_en) begin
         x_lo_ff <= x0c;
         x_hi_ff <= x1c;
         y_ff    <= y0c;
         y_hi_ff <= y1c;
      end else if (cmd.emit_en && sts.col_last) begin
         y_ff <= y_ff + DW'(1);
      end
      if (cmd.row_en) begin
         base_ff <= PW'(y_ff) * PW'(w);
         x_ff    <= x_lo_ff;
      end else if (cmd.emit_en) begin
         x_ff <= x_ff + DW'(1);
      end
   end

   // output beat register
   logic                 rsp_valid_ff;
   csb_pkg::csb_rsp_type rsp_ff;
   logic [SW-1:0]        addr_sum;

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign addr_sum     = SW'(base_ff) + SW'(x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_en) begin
         rsp_ff.dst_addr <= addr_sum[csb_pkg::ADDR_W-1:0];
         rsp_ff.color    <= color_ff;
         rsp_ff.last     <= sts.col_last && sts.row_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### verif/tb_clipped_scaled_pixel_blitter.sv
// testbench for clipped_scaled_pixel_blitter: directed and random pixel beats with
// a cycle-free predictor of the destination writes, checked beat by beat
// depends on csb_pkg and the blitter rtl
`timescale 1ns / 1ps
`default_nettype none

module tb_clipped_scaled_pixel_blitter;

   localparam longint  MAX_DIM       = 4096;
   localparam int      FRAC_BITS     = 4;
   localparam longint  SCALE_CAP     = 128;
   localparam int      SETTLE_CYCLES = 24;
   localparam int      MAX_REPORTS   = 10;
   localparam logic [csb_pkg::CSR_IDX_W-1:0] CSR_NO_REG = 3'd7;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   csb_pkg::csb_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   csb_pkg::csb_rsp_type rsp_data;
   logic                           csr_wr_en = 1'b0;
   logic [csb_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [csb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // copy of the register file and source position
   logic [12:0]        cfg_dst_w   = '0;
   logic [12:0]        cfg_dst_h   = '0;
   logic signed [12:0] cfg_pos_x   = '0;
   logic signed [12:0] cfg_pos_y   = '0;
   logic [7:0]         cfg_scale_x = csb_pkg::SCALE_RESET;
   logic [7:0]         cfg_scale_y = csb_pkg::SCALE_RESET;
   logic [12:0]        cfg_rect_w  = csb_pkg::RECT_RESET;
   logic [11:0]        src_col     = '0;
   logic [11:0]        src_row     = '0;

   csb_pkg::csb_req_type pixel_queue[$];
   csb_pkg::csb_rsp_type pending_writes[$];
   int          mismatch_count = 0;
   int          gap_pct        = 30;
   bit          hold_sender    = 1'b0;

   clipped_scaled_pixel_blitter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // expected destination writes of one pixel, then advance the source position
   task automatic predict_pixel_writes(input csb_pkg::csb_req_type px);
      longint sx, sy, x0q, y0q, xa, xb, ya, yb, w, h, lim, x, y;
      int nwr, k;
      csb_pkg::csb_rsp_type wr;
      if (px.start_req) begin
         src_col = '0;
         src_row = '0;
      end
      if (px.pixel_color[31:csb_pkg::ALPHA_LSB] == csb_pkg::ALPHA_OPAQUE) begin
         sx  = (longint'(cfg_scale_x) > SCALE_CAP) ? SCALE_CAP : longint'(cfg_scale_x);
         sy  = (longint'(cfg_scale_y) > SCALE_CAP) ? SCALE_CAP : longint'(cfg_scale_y);
         x0q = sx * longint'(src_col) + (longint'(cfg_pos_x) <<< FRAC_BITS);
         y0q = sy * longint'(src_row) + (longint'(cfg_pos_y) <<< FRAC_BITS);
         // arithmetic shift of a signed value is the floor
         xa  = x0q >>> FRAC_BITS;
         xb  = (x0q + sx) >>> FRAC_BITS;
         ya  = y0q >>> FRAC_BITS;
         yb  = (y0q + sy) >>> FRAC_BITS;
         w   = (longint'(cfg_dst_w) > MAX_DIM) ? MAX_DIM : longint'(cfg_dst_w);
         h   = (longint'(cfg_dst_h) > MAX_DIM) ? MAX_DIM : longint'(cfg_dst_h);
         if (!(xb < 0 || yb < 0 || xa > w || ya > h)) begin
            if (xa < 0) xa = 0;
            if (ya < 0) ya = 0;
            if (xb > w) xb = w;
            if (yb > h) yb = h;
            nwr = (xb > xa && yb > ya) ? int'((xb - xa) * (yb - ya)) : 0;
            k = 0;
            for (y = ya; y < yb; y++) begin
               for (x = xa; x < xb; x++) begin
                  wr.dst_addr = (csb_pkg::ADDR_W)'(y * w + x);
                  wr.color    = px.pixel_color;
                  wr.last     = (k == nwr - 1);
                  pending_writes.push_back(wr);
                  k++;
               end
            end
         end
      end
      // row-order walk over the source rectangle
      lim = (cfg_rect_w == 0) ? 1 :
            ((longint'(cfg_rect_w) > MAX_DIM) ? MAX_DIM : longint'(cfg_rect_w));
      if (longint'(src_col) + 1 >= lim) begin
         src_col = '0;
         src_row = (src_row == 12'hFFF) ? 12'd0 : src_row + 12'd1;
      end else begin
         src_col = src_col + 12'd1;
      end
   endtask

   // driver: one pixel beat at a time from the queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_pixel_writes(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (pixel_queue.size() != 0 && !hold_sender && $urandom_range(99) >= gap_pct) begin
               req_data  <= pixel_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each write beat with the oldest expected one
   always @(posedge clock) begin
      csb_pkg::csb_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_writes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected write beat: addr %h color %h last %b",
                           rsp_data.dst_addr, rsp_data.color, rsp_data.last);
            end else begin
               want = pending_writes.pop_front();
               if (rsp_data.dst_addr !== want.dst_addr || rsp_data.color !== want.color ||
                   rsp_data.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("write mismatch (addr color last): exp %h %h %b, got %h %h %b",
                              want.dst_addr, want.color, want.last,
                              rsp_data.dst_addr, rsp_data.color, rsp_data.last);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < gap_pct);
      end
   end

   // wait until the block has drained and had time to finish any silent pixel
   task automatic wait_idle();
      @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || pending_writes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [csb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [12:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         csb_pkg::CSR_DST_WIDTH:  cfg_dst_w   = val;
         csb_pkg::CSR_DST_HEIGHT: cfg_dst_h   = val;
         csb_pkg::CSR_POS_X:      cfg_pos_x   = val;
         csb_pkg::CSR_POS_Y:      cfg_pos_y   = val;
         csb_pkg::CSR_SCALE_X:    cfg_scale_x = val[7:0];
         csb_pkg::CSR_SCALE_Y:    cfg_scale_y = val[7:0];
         csb_pkg::CSR_RECT_WIDTH: cfg_rect_w  = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [12:0] dw, input logic [12:0] dh,
                             input logic [12:0] px, input logic [12:0] py,
                             input logic [12:0] scx, input logic [12:0] scy,
                             input logic [12:0] rw);
      wait_idle();
      write_reg(csb_pkg::CSR_DST_WIDTH, dw);
      write_reg(csb_pkg::CSR_DST_HEIGHT, dh);
      write_reg(csb_pkg::CSR_POS_X, px);
      write_reg(csb_pkg::CSR_POS_Y, py);
      write_reg(csb_pkg::CSR_SCALE_X, scx);
      write_reg(csb_pkg::CSR_SCALE_Y, scy);
      write_reg(csb_pkg::CSR_RECT_WIDTH, rw);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_pixel(input logic [31:0] color, input logic start);
      csb_pkg::csb_req_type px;
      px.pixel_color = color;
      px.start_req   = start;
      pixel_queue.push_back(px);
   endtask

   function automatic logic [31:0] opaque_color();
      return {csb_pkg::ALPHA_OPAQUE, 24'($urandom)};
   endfunction

   function automatic logic [31:0] clear_color();
      return {8'($urandom_range(254)), 24'($urandom)};
   endfunction

   function automatic logic [12:0] rand_dim();
      case ($urandom_range(9))
         0:       return 13'd0;
         1:       return 13'd4096;
         2:       return 13'($urandom_range(8191));
         default: return 13'($urandom_range(1, 48));
      endcase
   endfunction

   function automatic logic [12:0] rand_pos();
      case ($urandom_range(7))
         0:       return 13'($urandom);
         default: return 13'(int'($urandom_range(80)) - 30);
      endcase
   endfunction

   function automatic logic [12:0] rand_scale();
      case ($urandom_range(9))
         0:       return 13'd0;
         1:       return 13'd128;
         2:       return 13'($urandom);
         default: return 13'($urandom_range(4, 48));
      endcase
   endfunction

   // rectangles in row order with random content, plus some noise beats
   task automatic fill_random(input int n_items);
      int n, len, j;
      n = 0;
      while (n < n_items) begin
         if ($urandom_range(9) == 0) begin
            push_pixel($urandom, 1'($urandom));
            n++;
         end else begin
            len = $urandom_range(1, 12);
            for (j = 0; j < len; j++) begin
               push_pixel(($urandom_range(9) < 8) ? opaque_color() : clear_color(),
                          (j == 0) && ($urandom_range(11) != 0));
            end
            n += len;
         end
      end
   endtask

   // main sequence
   initial begin
      int ph;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // unscaled blit, alpha extremes and restart
      set_config(13'd40, 13'd30, 13'd0, 13'd0, 13'd16, 13'd16, 13'd4);
      push_pixel(32'hFFFF_FFFF, 1'b1);
      push_pixel(32'hFF00_0000, 1'b0);
      push_pixel(32'hFEFF_FFFF, 1'b0);
      push_pixel(32'h00FF_FFFF, 1'b0);
      push_pixel(32'hFF12_3456, 1'b0);
      push_pixel(32'h7FAB_CDEF, 1'b0);
      push_pixel(32'hFF65_4321, 1'b1);
      push_pixel(32'hFF00_FF00, 1'b0);
      push_pixel(32'h0000_0000, 1'b0);
      push_pixel(32'hFFA5_5A5A, 1'b0);

      // largest scale, scale saturation, left clip, oversized destination
      set_config(13'h1FFF, 13'h1FFF, 13'h1FFB, 13'd2, 13'd128, 13'h1FFF, 13'd0);
      write_reg(CSR_NO_REG, 13'h1FFF);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      push_pixel(32'hFF11_2233, 1'b1);
      push_pixel(32'hFF44_5566, 1'b0);
      push_pixel(32'hFF77_8899, 1'b0);

      // zero horizontal scale
      set_config(13'd20, 13'd20, 13'd0, 13'd0, 13'd0, 13'd24, 13'd3);
      push_pixel(32'hFFDE_AD00, 1'b1);
      push_pixel(32'hFFBE_EF00, 1'b0);

      // clipped at the right and top edges, empty and partial spans
      set_config(13'd16, 13'd16, 13'd15, 13'h1FFF, 13'd24, 13'd24, 13'd2);
      push_pixel(opaque_color(), 1'b1);
      push_pixel(opaque_color(), 1'b0);
      push_pixel(opaque_color(), 1'b0);
      push_pixel(opaque_color(), 1'b0);

      // position extremes, rejected
      set_config(13'd4096, 13'd4096, 13'h1000, 13'h0FFF, 13'd16, 13'd16, 13'h1FFF);
      push_pixel(opaque_color(), 1'b1);
      push_pixel(opaque_color(), 1'b0);
      set_config(13'd4096, 13'd4096, 13'h0FFF, 13'h1000, 13'd128, 13'd128, 13'd5);
      push_pixel(opaque_color(), 1'b1);
      push_pixel(opaque_color(), 1'b0);

      // random phases
      for (ph = 0; ph < 8; ph++) begin
         set_config(rand_dim(), rand_dim(), rand_pos(), rand_pos(),
                    rand_scale(), rand_scale(),
                    ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(1, 10)));
         gap_pct = (ph == 3) ? 0 : 30;
         fill_random(34);
         if (ph == 5) begin
            // sender holds off until every write has come back
            while (pixel_queue.size() > 20) @(negedge clock);
            hold_sender = 1'b1;
            while (req_valid || pending_writes.size() != 0) @(negedge clock);
            repeat (8) @(negedge clock);
            hold_sender = 1'b0;
         end
      end

      wait_idle();
      if (mismatch_count == 0 && pending_writes.size() == 0) begin
         $display("tb_clipped_scaled_pixel_blitter: PASS");
      end else begin
         $display("tb_clipped_scaled_pixel_blitter: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(64'd10_000_000);
      $display("tb_clipped_scaled_pixel_blitter: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
